/* rtl/sme_pkg.sv */
package sme_pkg;

    localparam int PEOPLE = 8;
    localparam int IW = 3;
    localparam int CW = $clog2(PEOPLE + 1);
    localparam int AW = $clog2(PEOPLE * PEOPLE);

    typedef enum logic [1:0] {
        OP_LOAD_PROP = 2'd0,
        OP_LOAD_ACC  = 2'd1,
        OP_RUN       = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_READ,
        ST_RANK,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Status that one proposer cell reports to the controller.
    typedef struct packed {
        logic          held;
        logic [IW-1:0] partner;
        logic [CW-1:0] next;
    } cell_stat_t;

    // Commands from the controller to every cell.
    typedef struct packed {
        logic          clear;
        logic          engage;
        logic          release_it;
        logic          advance;
        logic [IW-1:0] target;
        logic [IW-1:0] old_man;
        logic [IW-1:0] acc;
    } cell_cmd_t;

endpackage

/* rtl/sme_ram.sv */
module sme_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/sme_cell.sv */
module sme_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [sme_pkg::IW-1:0]  my_id,
    input  sme_pkg::cell_cmd_t      cmd,
    output sme_pkg::cell_stat_t     stat
);

    sme_pkg::cell_stat_t stat_reg, stat_next;

    // One proposer's match state and proposal pointer.
    always_comb
    begin
        stat_next = stat_reg;
        if (cmd.clear)
        begin
            stat_next = '0;
        end
        else
        begin
            if (cmd.advance && cmd.target == my_id)
            begin
                stat_next.next = stat_reg.next + 1'b1;
            end
            if (cmd.release_it && cmd.old_man == my_id)
            begin
                stat_next.held = 1'b0;
                stat_next.partner = '0;
            end
            if (cmd.engage && cmd.target == my_id)
            begin
                stat_next.held = 1'b1;
                stat_next.partner = cmd.acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else
        begin
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

/* rtl/stable_matching_engine_core.sv */
// Loads are written when accepted and stream one per cycle while the block is idle.
// A run, once accepted, makes up to PEOPLE*PEOPLE proposals of four steps each
// (free-proposer search, list read, rank read, decide), set by the registered reads of
// the preference RAMs, then one final search and PEOPLE results, one per
// proposer, each held while out_ready is low. Requests are refused during a run.
// Reset clears the cells' match state and the acceptor held flags; preference tables are undefined until written.
module stable_matching_engine_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [2:0] person,
    input  logic [2:0] rank,
    input  logic [2:0] choice,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] proposer,
    output logic [2:0] partner,
    output logic       matched,
    output logic       last
);

    localparam int IW = sme_pkg::IW;
    localparam int AW = sme_pkg::AW;

    sme_pkg::state_t state_reg, state_next;
    sme_pkg::cell_cmd_t cmd;
    sme_pkg::cell_stat_t stat [sme_pkg::PEOPLE];

    logic [IW-1:0] man_reg, man_next;
    logic [IW-1:0] acc_reg, acc_next;
    logic [IW-1:0] emit_reg, emit_next;
    logic [IW-1:0] rank_new_reg, rank_new_next;
    logic          found;
    logic [IW-1:0] found_id;
    logic [sme_pkg::PEOPLE-1:0] acc_held_reg, acc_held_next;
    logic [IW-1:0] acc_part_reg [sme_pkg::PEOPLE];
    logic [IW-1:0] acc_part_next [sme_pkg::PEOPLE];

    logic          pref_we, rank_we;
    logic [AW-1:0] pref_waddr, rank_waddr, pref_raddr, rank_raddr;
    logic [IW-1:0] pref_rdata, rank_rdata;
    logic          in_ok;

    // Row of proposer cells.
    for (genvar g = 0; g < sme_pkg::PEOPLE; g++)
    begin : g_cell
        sme_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .my_id (IW'(g)),
            .cmd   (cmd),
            .stat  (stat[g])
        );
    end

    // Preference list store, indexed proposer then rank.
    sme_ram #(.WIDTH(IW), .DEPTH(sme_pkg::PEOPLE * sme_pkg::PEOPLE)) u_pref (
        .clk(clk), .we(pref_we), .waddr(pref_waddr), .wdata(choice),
        .raddr(pref_raddr), .rdata(pref_rdata)
    );

    // Rank table store, indexed acceptor then proposer.
    sme_ram #(.WIDTH(IW), .DEPTH(sme_pkg::PEOPLE * sme_pkg::PEOPLE)) u_rank (
        .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank),
        .raddr(rank_raddr), .rdata(rank_rdata)
    );

    // Load addresses and range check.
    assign in_ok = (32'(person) < sme_pkg::PEOPLE) && (32'(rank) < sme_pkg::PEOPLE)
                   && (32'(choice) < sme_pkg::PEOPLE);
    assign pref_waddr = AW'(32'(person) * sme_pkg::PEOPLE + 32'(rank));
    assign rank_waddr = AW'(32'(person) * sme_pkg::PEOPLE + 32'(choice));
    assign in_ready = (state_reg == sme_pkg::ST_IDLE);
    assign pref_we = in_valid && in_ready && in_ok && (op == sme_pkg::OP_LOAD_PROP);
    assign rank_we = in_valid && in_ready && in_ok && (op == sme_pkg::OP_LOAD_ACC);

    // Lowest free proposer with entries left.
    always_comb
    begin
        found = 1'b0;
        found_id = '0;
        for (int i = sme_pkg::PEOPLE - 1; i >= 0; i--)
        begin
            if (!stat[i].held && 32'(stat[i].next) < sme_pkg::PEOPLE)
            begin
                found = 1'b1;
                found_id = IW'(i);
            end
        end
    end

    // The list read is issued during the search, for the proposer just found.
    assign pref_raddr = AW'(32'(man_next) * sme_pkg::PEOPLE + 32'(stat[man_next].next[IW-1:0]));
    assign rank_raddr = (state_reg == sme_pkg::ST_READ)
        ? AW'(32'(pref_rdata) * sme_pkg::PEOPLE + 32'(man_reg))
        : AW'(32'(acc_reg) * sme_pkg::PEOPLE + 32'(acc_part_reg[acc_reg]));

    // Controller: next state and cell commands.
    always_comb
    begin
        state_next = state_reg;
        man_next = man_reg;
        acc_next = acc_reg;
        emit_next = emit_reg;
        rank_new_next = rank_new_reg;
        acc_held_next = acc_held_reg;
        acc_part_next = acc_part_reg;
        cmd = '0;
        cmd.target = man_reg;
        cmd.acc = acc_reg;
        cmd.old_man = acc_part_reg[acc_reg];
        case (state_reg)
            sme_pkg::ST_IDLE:
            begin
                if (in_valid && op == sme_pkg::OP_RUN)
                begin
                    cmd.clear = 1'b1;
                    acc_held_next = '0;
                    state_next = sme_pkg::ST_FIND;
                end
            end
            sme_pkg::ST_FIND:
            begin
                man_next = found_id;
                emit_next = '0;
                state_next = found ? sme_pkg::ST_READ : sme_pkg::ST_EMIT;
            end
            sme_pkg::ST_READ:
            begin
                // Pointer read issued last cycle; data is the acceptor.
                acc_next = pref_rdata;
                cmd.advance = 1'b1;
                state_next = sme_pkg::ST_RANK;
            end
            sme_pkg::ST_RANK:
            begin
                rank_new_next = rank_rdata;
                state_next = sme_pkg::ST_DECIDE;
            end
            sme_pkg::ST_DECIDE:
            begin
                if (!acc_held_reg[acc_reg])
                begin
                    cmd.engage = 1'b1;
                    acc_held_next[acc_reg] = 1'b1;
                    acc_part_next[acc_reg] = man_reg;
                end
                else if (rank_new_reg < rank_rdata)
                begin
                    cmd.engage = 1'b1;
                    cmd.release_it = 1'b1;
                    acc_part_next[acc_reg] = man_reg;
                end
                state_next = sme_pkg::ST_FIND;
            end
            sme_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (32'(emit_reg) == sme_pkg::PEOPLE - 1)
                    begin
                        state_next = sme_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sme_pkg::ST_IDLE;
            emit_reg <= '0;
            acc_held_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg <= emit_next;
            acc_held_reg <= acc_held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        man_reg <= man_next;
        acc_reg <= acc_next;
        rank_new_reg <= rank_new_next;
        acc_part_reg <= acc_part_next;
    end

    // Results come straight from the cells, one per cycle while out_ready is high.
    assign out_valid = (state_reg == sme_pkg::ST_EMIT);
    assign proposer = emit_reg;
    assign matched = stat[emit_reg].held;
    assign partner = stat[emit_reg].held ? stat[emit_reg].partner : '0;
    assign last = (32'(emit_reg) == sme_pkg::PEOPLE - 1);

endmodule

/* rtl/sme_checker.sv */
module sme_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] proposer,
    input logic       matched,
    input logic [2:0] partner,
    input logic       last
);

    // The block never takes a request while it shows a result.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready during result");

    // Results count up by one proposer.
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && proposer == $past(proposer) + 3'd1)
        else $error("result order");

    // An unmatched proposer reports partner zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> partner == 3'd0) else $error("partner not zero");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(proposer)) else $error("result lost");

endmodule

bind stable_matching_engine_core sme_checker u_sme_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .proposer(proposer),
    .matched(matched), .partner(partner), .last(last)
);

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = sme_pkg::PEOPLE;
    localparam int IDLE_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [2:0] person;
    logic [2:0] rank;
    logic [2:0] choice;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] proposer;
    logic [2:0] partner;
    logic       matched;
    logic       last;

    typedef struct packed {
        logic [2:0] proposer;
        logic [2:0] partner;
        logic       matched;
        logic       last;
    } pairing_t;

    typedef struct {
        sme_pkg::op_t op;
        logic [2:0]   person;
        logic [2:0]   rank;
        logic [2:0]   choice;
    } request_t;

    stable_matching_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .person    (person),
        .rank      (rank),
        .choice    (choice),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .proposer  (proposer),
        .partner   (partner),
        .matched   (matched),
        .last      (last)
    );

    // Shadow copy of the preference tables.
    logic [2:0] man_list [N][N];
    logic [2:0] woman_rank [N][N];

    pairing_t   pairing_queue[$];
    int         errors;
    int         idle_cycles;
    logic       drain_phase;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Apply one request to the shadow tables and queue the pairings a run produces.
    task automatic predict_request(input request_t r);
        logic [2:0] man_partner [N];
        logic [2:0] woman_partner [N];
        logic       man_held [N];
        logic       woman_held [N];
        int         next_idx [N];
        int         m;
        int         w;
        int         cur;
        pairing_t   p;
        if (r.op == sme_pkg::OP_LOAD_PROP)
        begin
            man_list[r.person][r.rank] = r.choice;
        end
        else if (r.op == sme_pkg::OP_LOAD_ACC)
        begin
            woman_rank[r.person][r.choice] = r.rank;
        end
        else if (r.op == sme_pkg::OP_RUN)
        begin
            for (int i = 0; i < N; i++)
            begin
                man_held[i] = 1'b0;
                woman_held[i] = 1'b0;
                man_partner[i] = '0;
                woman_partner[i] = '0;
                next_idx[i] = 0;
            end
            forever
            begin
                m = N;
                for (int i = N - 1; i >= 0; i--)
                    if (!man_held[i] && next_idx[i] < N)
                        m = i;
                if (m == N)
                    break;
                w = man_list[m][next_idx[m]];
                next_idx[m]++;
                if (!woman_held[w])
                begin
                    woman_held[w] = 1'b1;
                    woman_partner[w] = 3'(m);
                    man_held[m] = 1'b1;
                    man_partner[m] = 3'(w);
                end
                else
                begin
                    cur = woman_partner[w];
                    if (woman_rank[w][m] < woman_rank[w][cur])
                    begin
                        man_held[cur] = 1'b0;
                        man_partner[cur] = '0;
                        woman_partner[w] = 3'(m);
                        man_held[m] = 1'b1;
                        man_partner[m] = 3'(w);
                    end
                end
            end
            for (int i = 0; i < N; i++)
            begin
                p.proposer = 3'(i);
                p.partner = man_held[i] ? man_partner[i] : 3'd0;
                p.matched = man_held[i];
                p.last = (i == N - 1);
                pairing_queue.push_back(p);
            end
        end
    endtask

    // Random gaps between requests; valid drops only for a gap.
    task automatic maybe_gap();
        int n;
        if (!drain_phase && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drive one request and wait until it is accepted.
    task automatic send_request(input request_t r);
        maybe_gap();
        in_valid <= 1'b1;
        op <= r.op;
        person <= r.person;
        rank <= r.rank;
        choice <= r.choice;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(r);
    endtask

    function automatic request_t mk(sme_pkg::op_t o, int a, int b, int c);
        request_t r;
        r.op = o;
        r.person = 3'(a);
        r.rank = 3'(b);
        r.choice = 3'(c);
        return r;
    endfunction

    // Load full permutation lists, or with lists sometimes left short of variety.
    task automatic load_tables(input int style);
        int perm [N];
        int j;
        int t;
        for (int who = 0; who < N; who++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                for (int i = 0; i < N; i++)
                    perm[i] = i;
                for (int i = N - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                for (int i = 0; i < N; i++)
                begin
                    if (style == 1)
                        t = $urandom_range(0, N - 1);
                    else if (style == 2)
                        t = $urandom_range(0, 1);
                    else
                        t = perm[i];
                    if (k == 0)
                        send_request(mk(sme_pkg::OP_LOAD_PROP, who, i, t));
                    else
                        send_request(mk(sme_pkg::OP_LOAD_ACC, who, t, i));
                end
            end
        end
    endtask

    // Result side: random stalls, field checks against the oldest expectation.
    initial
    begin
        int n;
        pairing_t exp_p;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pairing_queue.size() == 0)
                begin
                    $display("%0t: unexpected result proposer=%0d partner=%0d", $time,
                             proposer, partner);
                    errors++;
                end
                else
                begin
                    exp_p = pairing_queue.pop_front();
                    if (proposer !== exp_p.proposer)
                    begin
                        $display("%0t: proposer expected %0d actual %0d", $time,
                                 exp_p.proposer, proposer);
                        errors++;
                    end
                    if (partner !== exp_p.partner)
                    begin
                        $display("%0t: partner expected %0d actual %0d", $time,
                                 exp_p.partner, partner);
                        errors++;
                    end
                    if (matched !== exp_p.matched)
                    begin
                        $display("%0t: matched expected %0d actual %0d", $time,
                                 exp_p.matched, matched);
                        errors++;
                    end
                    if (last !== exp_p.last)
                    begin
                        $display("%0t: last expected %0d actual %0d", $time,
                                 exp_p.last, last);
                        errors++;
                    end
                end
            end
            if (!drain_phase && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no accepted handshake.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        request_t table_rows [$];
        pairing_t fixed [$];
        int       wait_cycles;
        errors = 0;
        idle_cycles = 0;
        drain_phase = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = sme_pkg::OP_NONE;
        person = '0;
        rank = '0;
        choice = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity lists, every man gets the woman of his own index.
        for (int i = 0; i < N; i++)
            for (int k = 0; k < N; k++)
            begin
                send_request(mk(sme_pkg::OP_LOAD_PROP, i, k, (i + k) % N));
                send_request(mk(sme_pkg::OP_LOAD_ACC, i, k, (i + k) % N));
            end
        // The unused op is ignored, and a run ignores its field values.
        table_rows.push_back(mk(sme_pkg::OP_NONE, 7, 7, 7));
        table_rows.push_back(mk(sme_pkg::OP_NONE, 0, 0, 0));
        table_rows.push_back(mk(sme_pkg::OP_RUN, 7, 7, 7));
        foreach (table_rows[i])
            send_request(table_rows[i]);
        // Typed expectation for the identity run, checked against the predictor.
        for (int i = 0; i < N; i++)
            fixed.push_back('{proposer: 3'(i), partner: 3'(i), matched: 1'b1,
                              last: i == N - 1});
        for (int i = 0; i < N; i++)
            if (pairing_queue[pairing_queue.size() - N + i] !== fixed[i])
            begin
                $display("%0t: identity run expected %0d actual %0d", $time, fixed[i].partner,
                         pairing_queue[pairing_queue.size() - N + i].partner);
                errors++;
            end
        // Everyone prefers acceptor 0 only: exhausted lists leave seven unmatched.
        for (int i = 0; i < N; i++)
            for (int k = 0; k < N; k++)
                send_request(mk(sme_pkg::OP_LOAD_PROP, i, k, 0));
        send_request(mk(sme_pkg::OP_RUN, 0, 0, 0));

        // Random: full permutation tables, then degenerate lists.
        for (int round = 0; round < 2; round++)
        begin
            load_tables(round);
            for (int k = 0; k < 6; k++)
            begin
                case ($urandom_range(0, 3))
                    0: send_request(mk(sme_pkg::OP_LOAD_PROP, $urandom_range(0, 7),
                                       $urandom_range(0, 7), $urandom_range(0, 7)));
                    1: send_request(mk(sme_pkg::OP_LOAD_ACC, $urandom_range(0, 7),
                                       $urandom_range(0, 7), $urandom_range(0, 7)));
                    2: send_request(mk(sme_pkg::OP_NONE, $urandom_range(0, 7),
                                       $urandom_range(0, 7), $urandom_range(0, 7)));
                    default: send_request(mk(sme_pkg::OP_RUN, $urandom_range(0, 7),
                                             $urandom_range(0, 7), $urandom_range(0, 7)));
                endcase
            end
            send_request(mk(sme_pkg::OP_RUN, 0, 0, 0));
        end
        // Last stretch without idling.
        drain_phase = 1'b1;
        for (int k = 0; k < 20; k++)
            send_request(mk(sme_pkg::op_t'($urandom_range(0, 2)), $urandom_range(0, 7),
                            $urandom_range(0, 7), $urandom_range(0, 7)));
        send_request(mk(sme_pkg::OP_RUN, 0, 0, 0));
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pairing_queue.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && pairing_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
